// ===== hw/rtl/ceq_pkg.sv =====
// Shared types and constants for the coalescing event queue.
// Used by coalescing_event_queue_top; no dependencies.
package ceq_pkg;

  localparam int QUEUE_DEPTH_DEF = 128;

  localparam logic       ACT_PUSH = 1'b0;
  localparam logic       ACT_POP  = 1'b1;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_KEY      = 3'd1;
  localparam logic [2:0] KIND_CHAR     = 3'd2;
  localparam logic [2:0] KIND_MOUSE    = 3'd3;
  localparam logic [2:0] KIND_JOY_AXIS = 3'd4;
  localparam logic [2:0] KIND_CONSOLE  = 3'd5;

  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_MERGED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic               action;
    logic [31:0]        now_ms;
    logic [31:0]        event_time;
    logic [2:0]         event_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [15:0]        payload_length;
    logic [31:0]        payload_handle;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        out_time;
    logic [2:0]         out_kind;
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic [15:0]        out_length;
    logic [31:0]        out_handle;
  } result_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [2:0]         kind;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic [15:0]        length;
    logic [31:0]        handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/ceq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module ceq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/coalescing_event_queue_top.sv =====
// Top level of the coalescing event queue: command register, slot RAM, result register.
// Depends on ceq_pkg and ceq_ram.
//
// Usage:
//   A command beat (cmd) is taken at a clock edge with start high and busy low.
//   busy is always low: one push or pop is taken every cycle.
//   A push stores an event in a ring of QUEUE_DEPTH slots, merges a mouse event
//   into a queued mouse event that is the newest entry, or, when the ring is
//   full, overwrites the oldest entry and returns its handle.
//   A pop returns the oldest entry, or an empty kind-0 event carrying now_ms.
//   Each command gives exactly one result beat: done is high for one cycle with
//   the result on result, after the command and result registers. Results
//   cannot be held off; the receiver must take each beat in the cycle it is shown.
//   Throughput is one command per cycle. Each command is one slot read and at
//   most one slot write in the slot RAM; the oldest slot is read in the cycle
//   the command is taken, with a write from the command ahead forwarded.
//   Reset empties the ring; the slot RAM itself is not cleared, since only
//   queued slots are ever used.
module coalescing_event_queue_top #(
  parameter int QUEUE_DEPTH = ceq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ceq_pkg::cmd_t    cmd,
  output logic             done,
  output ceq_pkg::result_t result
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic             stage_vld;
  ceq_pkg::cmd_t    stage_cmd;

  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  logic             wr_lap, wr_lap_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic             rd_lap, rd_lap_next;
  logic [IDX_W-1:0] newest_idx, newest_idx_next;
  ceq_pkg::entry_t  newest, newest_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ceq_pkg::entry_t  ram_wdata;
  ceq_pkg::entry_t  ram_rdata;
  logic             byp;
  ceq_pkg::entry_t  byp_data;
  ceq_pkg::entry_t  oldest;

  ceq_pkg::result_t result_next;
  logic             empty, full;
  logic [31:0]      etime;
  ceq_pkg::entry_t  merged;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign busy   = 1'b0;
  assign empty  = (wr_idx == rd_idx) && (wr_lap == rd_lap);
  assign full   = (wr_idx == rd_idx) && (wr_lap != rd_lap);
  assign oldest = byp ? byp_data : ram_rdata;
  assign etime  = (stage_cmd.event_time == '0) ? stage_cmd.now_ms : stage_cmd.event_time;

  always_comb begin
    merged        = newest;
    merged.time_ms = etime;
    merged.first  = newest.first + stage_cmd.first_value;
    merged.second = newest.second + stage_cmd.second_value;
  end

  always_comb begin
    wr_idx_next     = wr_idx;
    wr_lap_next     = wr_lap;
    rd_idx_next     = rd_idx;
    rd_lap_next     = rd_lap;
    newest_idx_next = newest_idx;
    newest_next     = newest;
    ram_we          = 1'b0;
    ram_waddr       = wr_idx;
    ram_wdata       = '{etime, stage_cmd.event_kind, stage_cmd.first_value,
                        stage_cmd.second_value, stage_cmd.payload_length,
                        stage_cmd.payload_handle};
    result_next     = '0;
    if (stage_vld) begin
      if (stage_cmd.action == ceq_pkg::ACT_POP) begin
        if (empty) begin
          result_next.status   = ceq_pkg::ST_EMPTY;
          result_next.out_time = stage_cmd.now_ms;
        end else begin
          result_next.status     = ceq_pkg::ST_POPPED;
          result_next.out_time   = oldest.time_ms;
          result_next.out_kind   = oldest.kind;
          result_next.out_first  = oldest.first;
          result_next.out_second = oldest.second;
          result_next.out_length = oldest.length;
          result_next.out_handle = oldest.handle;
          rd_idx_next = idx_inc(rd_idx);
          rd_lap_next = rd_lap ^ (rd_idx == LAST_IDX);
        end
      end else if (stage_cmd.event_kind == ceq_pkg::KIND_MOUSE && !empty &&
                   newest.kind == ceq_pkg::KIND_MOUSE) begin
        result_next.status = ceq_pkg::ST_MERGED;
        ram_we      = 1'b1;
        ram_waddr   = newest_idx;
        ram_wdata   = merged;
        newest_next = merged;
      end else begin
        result_next.status = ceq_pkg::ST_QUEUED;
        if (full) begin
          result_next.status     = ceq_pkg::ST_DROPPED;
          result_next.out_handle = oldest.handle;
          rd_idx_next = idx_inc(rd_idx);
          rd_lap_next = rd_lap ^ (rd_idx == LAST_IDX);
        end
        ram_we          = 1'b1;
        ram_waddr       = wr_idx;
        newest_next     = ram_wdata;
        newest_idx_next = wr_idx;
        wr_idx_next     = idx_inc(wr_idx);
        wr_lap_next     = wr_lap ^ (wr_idx == LAST_IDX);
      end
    end
  end

  ceq_ram #(
    .WIDTH (ceq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld  <= 1'b0;
      done       <= 1'b0;
      wr_idx     <= '0;
      wr_lap     <= 1'b0;
      rd_idx     <= '0;
      rd_lap     <= 1'b0;
      newest_idx <= LAST_IDX;
    end else begin
      stage_vld  <= start;
      done       <= stage_vld;
      wr_idx     <= wr_idx_next;
      wr_lap     <= wr_lap_next;
      rd_idx     <= rd_idx_next;
      rd_lap     <= rd_lap_next;
      newest_idx <= newest_idx_next;
    end
  end

  // command and result registers; forward a slot write that lands on the slot being read
  always_ff @(posedge clk) begin
    if (start) begin
      stage_cmd <= cmd;
    end
    byp      <= ram_we && (ram_waddr == rd_idx_next);
    byp_data <= ram_wdata;
    newest   <= newest_next;
    result   <= result_next;
  end

endmodule

// ===== test/ceq_result_checker.sv =====
// Checker for the coalescing event queue: watches command and result beats,
// keeps its own ring of event slots and compares every result. Depends on ceq_pkg.
module ceq_result_checker #(
  parameter int QUEUE_DEPTH = ceq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  ceq_pkg::cmd_t    cmd,
  input  logic             done,
  input  ceq_pkg::result_t result,
  output int               outstanding,
  output int               error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_MOD = 2 * QUEUE_DEPTH;

  logic [31:0]        ring_time   [QUEUE_DEPTH];
  logic [2:0]         ring_kind   [QUEUE_DEPTH];
  logic signed [31:0] ring_first  [QUEUE_DEPTH];
  logic signed [31:0] ring_second [QUEUE_DEPTH];
  logic [15:0]        ring_length [QUEUE_DEPTH];
  logic [31:0]        ring_handle [QUEUE_DEPTH];
  int                 wr_cnt;
  int                 rd_cnt;
  logic [IDX_W-1:0]   newest;

  ceq_pkg::result_t   expected_results[$];
  int                 err_cnt = 0;

  assign error_count = err_cnt;

  function automatic ceq_pkg::result_t apply_event_cmd(ceq_pkg::cmd_t c);
    ceq_pkg::result_t r;
    int               occ;
    logic [IDX_W-1:0] s;
    logic [31:0]      t;
    r   = '0;
    occ = (wr_cnt + CNT_MOD - rd_cnt) % CNT_MOD;
    if (c.action == ceq_pkg::ACT_POP) begin
      if (occ == 0) begin
        r.status   = ceq_pkg::ST_EMPTY;
        r.out_time = c.now_ms;
      end else begin
        s            = IDX_W'(rd_cnt % QUEUE_DEPTH);
        r.status     = ceq_pkg::ST_POPPED;
        r.out_time   = ring_time[s];
        r.out_kind   = ring_kind[s];
        r.out_first  = ring_first[s];
        r.out_second = ring_second[s];
        r.out_length = ring_length[s];
        r.out_handle = ring_handle[s];
        rd_cnt       = (rd_cnt + 1) % CNT_MOD;
      end
      return r;
    end
    t = (c.event_time == 32'd0) ? c.now_ms : c.event_time;
    if (c.event_kind == ceq_pkg::KIND_MOUSE && occ != 0 &&
        ring_kind[newest] == ceq_pkg::KIND_MOUSE) begin
      ring_first[newest]  = ring_first[newest] + c.first_value;
      ring_second[newest] = ring_second[newest] + c.second_value;
      ring_time[newest]   = t;
      r.status            = ceq_pkg::ST_MERGED;
      return r;
    end
    s        = IDX_W'(wr_cnt % QUEUE_DEPTH);
    r.status = ceq_pkg::ST_QUEUED;
    if (occ >= QUEUE_DEPTH) begin
      r.status     = ceq_pkg::ST_DROPPED;
      r.out_handle = ring_handle[s];
      rd_cnt       = (rd_cnt + 1) % CNT_MOD;
    end
    wr_cnt         = (wr_cnt + 1) % CNT_MOD;
    ring_time[s]   = t;
    ring_kind[s]   = c.event_kind;
    ring_first[s]  = c.first_value;
    ring_second[s] = c.second_value;
    ring_length[s] = c.payload_length;
    ring_handle[s] = c.payload_handle;
    newest         = s;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    ceq_pkg::result_t exp_r;
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ring_time[i]   = '0;
        ring_kind[i]   = ceq_pkg::KIND_NONE;
        ring_first[i]  = '0;
        ring_second[i] = '0;
        ring_length[i] = '0;
        ring_handle[i] = '0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      newest = IDX_W'(QUEUE_DEPTH - 1);
      expected_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: actual %h", $time, result);
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("status", exp_r.status, result.status);
          compare_field("out_time", exp_r.out_time, result.out_time);
          compare_field("out_kind", exp_r.out_kind, result.out_kind);
          compare_field("out_first", exp_r.out_first, result.out_first);
          compare_field("out_second", exp_r.out_second, result.out_second);
          compare_field("out_length", exp_r.out_length, result.out_length);
          compare_field("out_handle", exp_r.out_handle, result.out_handle);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_results.push_back(apply_event_cmd(cmd));
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== test/coalescing_event_queue_top_tb.sv =====
// Testbench top for coalescing_event_queue_top: drives push and pop beats with
// random gaps and gives the verdict. Depends on ceq_pkg, coalescing_event_queue_top and ceq_result_checker.
module coalescing_event_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  ceq_pkg::cmd_t    cmd = '0;
  logic             done;
  ceq_pkg::result_t result;
  int               outstanding;
  int               error_count;
  bit               no_idle = 1'b0;

  coalescing_event_queue_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  ceq_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .outstanding (outstanding),
    .error_count (error_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("coalescing_event_queue_top_tb: FAIL");
    $finish;
  end

  function automatic ceq_pkg::cmd_t make_cmd(logic act, logic [31:0] now, logic [31:0] etime,
                                             logic [2:0] kind, logic [31:0] v1,
                                             logic [31:0] v2, logic [15:0] len,
                                             logic [31:0] handle);
    ceq_pkg::cmd_t c;
    c.action         = act;
    c.now_ms         = now;
    c.event_time     = etime;
    c.event_kind     = kind;
    c.first_value    = v1;
    c.second_value   = v2;
    c.payload_length = len;
    c.payload_handle = handle;
    return c;
  endfunction

  function automatic ceq_pkg::cmd_t random_cmd(int push_pct);
    logic [2:0]  kind;
    logic [31:0] etime;
    kind  = ($urandom_range(0, 99) < 30) ? ceq_pkg::KIND_MOUSE : 3'($urandom_range(0, 7));
    etime = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    return make_cmd(($urandom_range(0, 99) < push_pct) ? ceq_pkg::ACT_PUSH : ceq_pkg::ACT_POP,
                    $urandom, etime, kind, $urandom, $urandom, 16'($urandom), $urandom);
  endfunction

  task automatic send_beat(ceq_pkg::cmd_t c);
    int gap;
    if ($urandom_range(0, 19) == 0)
      no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_random(int count, int push_pct);
    for (int i = 0; i < count; i++)
      send_beat(random_cmd(push_pct));
    drain_results();
  endtask

  initial begin
    ceq_pkg::cmd_t directed[$];
    directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'h0, 32'h0, ceq_pkg::KIND_NONE,
                                0, 0, 0, 0));
    directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'hFFFF_FFFF, 32'h1, 3'd7,
                                '1, '1, '1, '1));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd12345, 32'h0, ceq_pkg::KIND_KEY,
                                32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'h0, 32'hFFFF_FFFF, ceq_pkg::KIND_CHAR,
                                32'h0, 32'hFFFF_FFFF, 16'h0, 32'h0));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd50, 32'd100, ceq_pkg::KIND_MOUSE,
                                32'h7FFF_FFFF, 32'h1, 16'd4, 32'hA5A5_0001));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd200, 32'h0, ceq_pkg::KIND_MOUSE,
                                32'h1, 32'hFFFF_FFFF, 16'd9, 32'hA5A5_0002));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd300, 32'd300, ceq_pkg::KIND_MOUSE,
                                32'h8000_0000, 32'h8000_0000, 16'd1, 32'hA5A5_0003));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd400, 32'd401, ceq_pkg::KIND_JOY_AXIS,
                                -5, 5, 16'd2, 32'h11));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd500, 32'd0, ceq_pkg::KIND_MOUSE,
                                3, -3, 16'd0, 32'h12));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd600, 32'd601, ceq_pkg::KIND_CONSOLE,
                                1, 2, 16'd3, 32'h13));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd700, 32'd701, 3'd6,
                                4, 5, 16'd6, 32'h14));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd800, 32'd801, 3'd7,
                                7, 8, 16'd9, 32'h15));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd900, 32'd901, ceq_pkg::KIND_NONE,
                                0, 1, 16'd1, 32'h16));
    for (int i = 0; i < 10; i++)
      directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'd1000 + i, 32'h0, ceq_pkg::KIND_NONE,
                                  0, 0, 0, 0));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd2000, 32'd2001, ceq_pkg::KIND_MOUSE,
                                10, 20, 16'd1, 32'h21));
    directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'd2100, 32'h0, ceq_pkg::KIND_NONE,
                                0, 0, 0, 0));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd2200, 32'h0, ceq_pkg::KIND_MOUSE,
                                30, 40, 16'd2, 32'h22));
    directed.push_back(make_cmd(ceq_pkg::ACT_PUSH, 32'd2300, 32'd2301, ceq_pkg::KIND_MOUSE,
                                50, 60, 16'd3, 32'h23));
    directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'd2400, 32'h0, ceq_pkg::KIND_NONE,
                                0, 0, 0, 0));
    directed.push_back(make_cmd(ceq_pkg::ACT_POP, 32'd2500, 32'h0, ceq_pkg::KIND_NONE,
                                0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_beat(directed[i]);
    drain_results();

    run_random(200, 95);
    run_random(100, 40);
    run_random(150, 10);

    repeat (8) @(posedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("coalescing_event_queue_top_tb: PASS");
    else
      $display("coalescing_event_queue_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== coalescing_event_queue_top.f =====
hw/rtl/ceq_pkg.sv
hw/rtl/ceq_ram.sv
hw/rtl/coalescing_event_queue_top.sv
test/ceq_result_checker.sv
test/coalescing_event_queue_top_tb.sv
